// ===== sv/smbr_pkg.sv =====
// shared types, codes and constants of the splitmix64 bounded random block
// no dependencies; imported by smbr_ctrl, smbr_dp and the top level
`default_nettype none

package smbr_pkg;

   localparam int unsigned WordW = 64;
   localparam int unsigned HalfW = WordW / 2;

   // splitmix64 constants
   localparam logic [WordW-1:0] GoldenInc  = 64'h9e3779b97f4a7c15;
   localparam logic [WordW-1:0] MixMulA    = 64'hbf58476d1ce4e5b9;
   localparam logic [WordW-1:0] MixMulB    = 64'h94d049bb133111eb;
   localparam logic [WordW-1:0] AttemptMul = 64'hd1b54a32d192ed03;
   localparam int unsigned MixShift1 = 30;
   localparam int unsigned MixShift2 = 27;
   localparam int unsigned MixShift3 = 31;

   localparam int unsigned FuncW    = 2;
   localparam int unsigned AttemptW = 16;

   // request function codes
   localparam logic [FuncW-1:0] FUNC_RAW     = 2'd0;
   localparam logic [FuncW-1:0] FUNC_BOUNDED = 2'd1;
   localparam logic [FuncW-1:0] FUNC_RESEED  = 2'd2;
   localparam logic [FuncW-1:0] FUNC_UNUSED  = 2'd3;

   // operations on the working word z
   localparam logic [2:0] ZOP_HOLD    = 3'd0;
   localparam logic [2:0] ZOP_X30     = 3'd1;  // z ^= z >> 30
   localparam logic [2:0] ZOP_ACC_X27 = 3'd2;  // z = acc ^ (acc >> 27)
   localparam logic [2:0] ZOP_ACC_X31 = 3'd3;  // z = acc ^ (acc >> 31)
   localparam logic [2:0] ZOP_STEP    = 3'd4;  // state += inc, z = new state
   localparam logic [2:0] ZOP_SEED    = 3'd5;  // z = (seed ^ acc) + inc
   localparam logic [2:0] ZOP_ZERO    = 3'd6;
   localparam logic [2:0] ZOP_REM     = 3'd7;  // z = divider remainder

   // multiplier source: operand and constant
   localparam logic [1:0] MSRC_ATT = 2'd0;
   localparam logic [1:0] MSRC_A   = 2'd1;
   localparam logic [1:0] MSRC_B   = 2'd2;

   // partial product select
   localparam logic [1:0] PP_LL = 2'd0;
   localparam logic [1:0] PP_LH = 2'd1;
   localparam logic [1:0] PP_HL = 2'd2;

   // accumulator operation
   localparam logic [1:0] ACC_NONE   = 2'd0;
   localparam logic [1:0] ACC_LOAD   = 2'd1;
   localparam logic [1:0] ACC_ADD_HI = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic [2:0] zop;
      logic [1:0] msrc;
      logic [1:0] pp_sel;
      logic       pp_en;
      logic [1:0] acc_op;
      logic       div_init_thr;
      logic       div_init_draw;
      logic       div_step;
      logic       thr_load;
      logic       state_from_z;
      logic       res_load;
   } cmd_type;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic             bound_small;
      logic             z_ge_thr;
   } stat_type;

   function automatic logic [WordW-1:0] mul_const(input logic [1:0] msrc);
      logic [WordW-1:0] c;
      unique case (msrc)
         MSRC_ATT: c = AttemptMul;
         MSRC_A:   c = MixMulA;
         MSRC_B:   c = MixMulB;
         default:  c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/smbr_dp.sv =====
// datapath: generator state, mix word, shared 32x32 multiplier, serial divider
// depends on smbr_pkg; driven by smbr_ctrl commands
`default_nettype none

module smbr_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [smbr_pkg::WordW-1:0]        csr_write_data,
   input  wire logic [smbr_pkg::FuncW-1:0]        req_func,
   input  wire logic [smbr_pkg::WordW-1:0]        req_bound,
   input  wire logic [smbr_pkg::AttemptW-1:0]     req_attempt_index,
   input  wire smbr_pkg::cmd_type                 cmd,
   output smbr_pkg::stat_type                     stat,
   output logic [smbr_pkg::WordW-1:0]             rsp_value
);
   import smbr_pkg::*;

   logic [WordW-1:0]    seed_ff, seed_in;
   logic [WordW-1:0]    state_ff, state_in;
   logic [FuncW-1:0]    func_ff;
   logic [WordW-1:0]    bound_ff;
   logic [AttemptW:0]   att_p1_ff;
   logic [WordW-1:0]    z_ff, z_in;
   logic [WordW-1:0]    prod_ff;
   logic [WordW-1:0]    acc_ff;
   logic [WordW-1:0]    rem_ff;
   logic [WordW-1:0]    dvd_ff;
   logic [WordW-1:0]    thr_ff;
   logic [WordW-1:0]    res_ff;

   logic [WordW-1:0]    state_inc;
   logic [WordW-1:0]    mul_x;
   logic [WordW-1:0]    mul_c;
   logic [HalfW-1:0]    mul_a;
   logic [HalfW-1:0]    mul_b;
   logic [WordW:0]      trial;
   logic                trial_ge;

   assign state_inc = state_ff + GoldenInc;

   // seed register and generator state
   always_comb begin
      seed_in  = seed_ff;
      state_in = state_ff;
      if (csr_write_en) begin
         seed_in  = csr_write_data;
         state_in = csr_write_data;
      end else if (cmd.zop == ZOP_STEP) begin
         state_in = state_inc;
      end else if (cmd.state_from_z) begin
         state_in = z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         state_ff <= '0;
      end else begin
         seed_ff  <= seed_in;
         state_ff <= state_in;
      end
   end

   // latched request beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff   <= req_func;
         bound_ff  <= req_bound;
         att_p1_ff <= {1'b0, req_attempt_index} + (AttemptW+1)'(1);
      end
   end

   // working word
   always_comb begin
      unique case (cmd.zop)
         ZOP_HOLD:    z_in = z_ff;
         ZOP_X30:     z_in = z_ff ^ (z_ff >> MixShift1);
         ZOP_ACC_X27: z_in = acc_ff ^ (acc_ff >> MixShift2);
         ZOP_ACC_X31: z_in = acc_ff ^ (acc_ff >> MixShift3);
         ZOP_STEP:    z_in = state_inc;
         ZOP_SEED:    z_in = (seed_ff ^ acc_ff) + GoldenInc;
         ZOP_ZERO:    z_in = '0;
         ZOP_REM:     z_in = rem_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
   end

   // low 64 bits of x * c from three 32x32 partial products
   assign mul_x = (cmd.msrc == MSRC_ATT) ? {{(WordW-AttemptW-1){1'b0}}, att_p1_ff} : z_ff;
   assign mul_c = mul_const(cmd.msrc);
   assign mul_a = (cmd.pp_sel == PP_HL) ? mul_x[WordW-1:HalfW] : mul_x[HalfW-1:0];
   assign mul_b = (cmd.pp_sel == PP_LH) ? mul_c[WordW-1:HalfW] : mul_c[HalfW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.pp_en) begin
         prod_ff <= {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};
      end
      unique case (cmd.acc_op)
         ACC_NONE:   acc_ff <= acc_ff;
         ACC_LOAD:   acc_ff <= prod_ff;
         ACC_ADD_HI: acc_ff <= acc_ff + {prod_ff[HalfW-1:0], {HalfW{1'b0}}};
         default:    acc_ff <= acc_ff;
      endcase
   end

   // restoring divider, remainder only, one quotient bit a cycle
   assign trial    = {rem_ff, dvd_ff[WordW-1]};
   assign trial_ge = trial >= {1'b0, bound_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init_thr) begin
         rem_ff <= '0;
         dvd_ff <= '0 - bound_ff;
      end else if (cmd.div_init_draw) begin
         rem_ff <= '0;
         dvd_ff <= z_ff;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? WordW'(trial - {1'b0, bound_ff}) : trial[WordW-1:0];
         dvd_ff <= {dvd_ff[WordW-2:0], 1'b0};
      end
      if (cmd.thr_load) begin
         thr_ff <= rem_ff;
      end
      if (cmd.res_load) begin
         res_ff <= z_ff;
      end
   end

   assign stat.func        = func_ff;
   assign stat.bound_small = (bound_ff[WordW-1:1] == '0);
   assign stat.z_ge_thr    = (z_ff >= thr_ff);
   assign rsp_value        = res_ff;

endmodule

`default_nettype wire

// ===== sv/smbr_ctrl.sv =====
// controller: sequences mix, multiply, divide and rejection loop
// depends on smbr_pkg; drives smbr_dp through cmd_type
`default_nettype none

module smbr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire smbr_pkg::stat_type  stat,
   output smbr_pkg::cmd_type        cmd
);
   import smbr_pkg::*;

   localparam int unsigned StateW   = 4;
   localparam int unsigned DivSteps = WordW;
   localparam int unsigned CntW     = $clog2(DivSteps);
   localparam int unsigned MulSteps = 4;
   localparam int unsigned MulCntW  = $clog2(MulSteps);

   localparam logic [StateW-1:0] S_IDLE     = 4'd0;
   localparam logic [StateW-1:0] S_DISPATCH = 4'd1;
   localparam logic [StateW-1:0] S_SEED     = 4'd2;
   localparam logic [StateW-1:0] S_X30      = 4'd3;
   localparam logic [StateW-1:0] S_MUL_T    = 4'd4;
   localparam logic [StateW-1:0] S_MUL_A    = 4'd5;
   localparam logic [StateW-1:0] S_X27      = 4'd6;
   localparam logic [StateW-1:0] S_MUL_B    = 4'd7;
   localparam logic [StateW-1:0] S_X31      = 4'd8;
   localparam logic [StateW-1:0] S_MIXED    = 4'd9;
   localparam logic [StateW-1:0] S_DIV_THR  = 4'd10;
   localparam logic [StateW-1:0] S_THR      = 4'd11;
   localparam logic [StateW-1:0] S_DIV_OUT  = 4'd12;
   localparam logic [StateW-1:0] S_REM      = 4'd13;
   localparam logic [StateW-1:0] S_OUT      = 4'd14;

   logic [StateW-1:0] state_ff, state_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              mul_last;
   logic              div_last;

   assign mul_last = (cnt_ff[MulCntW-1:0] == MulCntW'(MulSteps - 1));
   assign div_last = (cnt_ff == CntW'(DivSteps - 1));

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      cmd               = '0;
      cmd.zop           = ZOP_HOLD;
      cmd.acc_op        = ACC_NONE;
      cmd.msrc          = MSRC_A;
      cmd.pp_sel        = PP_LL;

      // shared partial product schedule for the three multiply states
      if (state_ff == S_MUL_T || state_ff == S_MUL_A || state_ff == S_MUL_B) begin
         unique case (cnt_ff[MulCntW-1:0])
            2'd0: begin
               cmd.pp_en  = 1'b1;
               cmd.pp_sel = PP_LL;
            end
            2'd1: begin
               cmd.pp_en  = 1'b1;
               cmd.pp_sel = PP_LH;
               cmd.acc_op = ACC_LOAD;
            end
            2'd2: begin
               cmd.pp_en  = 1'b1;
               cmd.pp_sel = PP_HL;
               cmd.acc_op = ACC_ADD_HI;
            end
            2'd3: begin
               cmd.acc_op = ACC_ADD_HI;
            end
         endcase
         cnt_in = cnt_ff + CntW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cnt_in = '0;
            unique case (stat.func)
               FUNC_RAW: begin
                  cmd.zop  = ZOP_STEP;
                  state_in = S_X30;
               end
               FUNC_BOUNDED: begin
                  if (stat.bound_small) begin
                     cmd.zop  = ZOP_ZERO;
                     state_in = S_OUT;
                  end else begin
                     cmd.div_init_thr = 1'b1;
                     state_in         = S_DIV_THR;
                  end
               end
               FUNC_RESEED: begin
                  state_in = S_MUL_T;
               end
               FUNC_UNUSED: begin
                  cmd.zop  = ZOP_ZERO;
                  state_in = S_OUT;
               end
            endcase
         end
         S_MUL_T: begin
            cmd.msrc = MSRC_ATT;
            if (mul_last) begin
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            cmd.zop  = ZOP_SEED;
            state_in = S_X30;
         end
         S_X30: begin
            cmd.zop  = ZOP_X30;
            cnt_in   = '0;
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            cmd.msrc = MSRC_A;
            if (mul_last) begin
               state_in = S_X27;
            end
         end
         S_X27: begin
            cmd.zop  = ZOP_ACC_X27;
            cnt_in   = '0;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.msrc = MSRC_B;
            if (mul_last) begin
               state_in = S_X31;
            end
         end
         S_X31: begin
            cmd.zop  = ZOP_ACC_X31;
            state_in = S_MIXED;
         end
         S_MIXED: begin
            cnt_in = '0;
            priority if (stat.func == FUNC_RESEED) begin
               cmd.state_from_z = 1'b1;
               state_in         = S_OUT;
            end else if (stat.func != FUNC_BOUNDED) begin
               state_in = S_OUT;
            end else if (stat.z_ge_thr) begin
               cmd.div_init_draw = 1'b1;
               state_in          = S_DIV_OUT;
            end else begin
               // rejected draw: advance the state and draw again
               cmd.zop  = ZOP_STEP;
               state_in = S_X30;
            end
         end
         S_DIV_THR: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CntW'(1);
            if (div_last) begin
               state_in = S_THR;
            end
         end
         S_THR: begin
            cmd.thr_load = 1'b1;
            cmd.zop      = ZOP_STEP;
            state_in     = S_X30;
         end
         S_DIV_OUT: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CntW'(1);
            if (div_last) begin
               state_in = S_REM;
            end
         end
         S_REM: begin
            cmd.zop  = ZOP_REM;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | cmd.res_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/splitmix64_bounded_random_top.sv =====
// splitmix64 generator with rejection-sampled bounded draws and reseed
// a bounded draw runs two 64-step serial divides (threshold, final remainder); a rejected
// draw repeats only the mix; a small bound or the unused code returns zero
// one request at a time; the serial divider and the shared 32x32 multiplier set the rate
// synchronous active-high reset: seed and generator state clear to zero, no beat pending
// depends on smbr_pkg, smbr_ctrl, smbr_dp
`default_nettype none

module splitmix64_bounded_random_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration: base seed, also reloads the generator state
   input  wire logic                          csr_write_en,
   input  wire logic [smbr_pkg::WordW-1:0]    csr_write_data,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [smbr_pkg::FuncW-1:0]    req_func,
   input  wire logic [smbr_pkg::WordW-1:0]    req_bound,
   input  wire logic [smbr_pkg::AttemptW-1:0] req_attempt_index,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [smbr_pkg::WordW-1:0]         rsp_value
);
   import smbr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller: one state per mix step, a 2-bit partial product phase inside
   // each multiply, and a 6-bit count for the 64 divider steps
   smbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: each 64x64 multiply (low half) takes three 32x32 partial
   // products, and the threshold and final remainder use a restoring divider;
   // the response register holds a finished beat so the next request beat
   // is taken while it waits
   smbr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_func          (req_func),
      .req_bound         (req_bound),
      .req_attempt_index (req_attempt_index),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_value         (rsp_value)
   );

endmodule

`default_nettype wire
